// ----- rtl/ramped_sine_voltage_source_unit_assert.svh -----
// Assertion macros shared by the checker of the ramped sine voltage source
`ifndef RAMPED_SINE_VOLTAGE_SOURCE_UNIT_ASSERT_SVH
`define RAMPED_SINE_VOLTAGE_SOURCE_UNIT_ASSERT_SVH

// Implication checked in the same cycle
`define RSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle
`define RSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rsv_pkg.sv -----
// Shared constants, tables and types of the ramped sine voltage source
package rsv_pkg;

  // default CORDIC depth and arctangent table length
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int TABLE_LEN = 40;

  // ramp fraction bits (Q30)
  localparam int LIN_W = 30;

  // CORDIC limit gain in Q24
  localparam logic signed [24:0] GAIN_Q24 = 25'sd10188014;

  // 2^64 / (2*pi), two 32-bit limbs
  localparam logic [31:0] INV2PI_LO = 32'h9391054A;
  localparam logic [31:0] INV2PI_HI = 32'h28BE60DB;

  // register indexes
  localparam logic [2:0] REG_REF_REAL    = 3'd0;
  localparam logic [2:0] REG_REF_IMAG    = 3'd1;
  localparam logic [2:0] REG_ADD_REAL    = 3'd2;
  localparam logic [2:0] REG_ADD_IMAG    = 3'd3;
  localparam logic [2:0] REG_BASE_OMEGA  = 3'd4;
  localparam logic [2:0] REG_ADD_OMEGA   = 3'd5;
  localparam logic [2:0] REG_SWITCH_TIME = 3'd6;
  localparam logic [2:0] REG_RAMP_LENGTH = 3'd7;

  // arctangent of 2^-i in turns, 2^-32 units
  localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5341269, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // pipeline control handed to each sub-unit
  typedef struct packed {
    logic valid;  // transaction entering the unit
    logic en;     // whole pipeline advances
  } ctl_t;

endpackage

// ----- rtl/rsv_divider.sv -----
// Pipelined restoring divider: one quotient bit of the ramp fraction per stage
module rsv_divider #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsv_pkg::ctl_t     ctl_i,
  input  logic [47:0]       rem_i,
  input  logic [47:0]       den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [rsv_pkg::LIN_W-1:0] quot_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int N = rsv_pkg::LIN_W;

  logic [N-1:0]  v_q;
  logic [47:0]   rem_q  [N];
  logic [N-1:0]  quot_q [N];
  logic [SIDE_W-1:0] side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic              v_in;
    logic [47:0]       rem_in;
    logic [N-1:0]      quot_in;
    logic [SIDE_W-1:0] side_in;
    logic [48:0]       shifted;
    logic [48:0]       trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = ctl_i.valid;
      assign rem_in  = rem_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign quot_in = quot_q[i-1];
      assign side_in = side_q[i-1];
    end

    // trial subtraction of the ramp length
    assign shifted = {rem_in, 1'b0};
    assign ge      = shifted >= {1'b0, den_i};
    assign trial   = shifted - {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[i]  <= ge ? trial[47:0] : shifted[47:0];
        quot_q[i] <= {quot_in[N-2:0], ge};
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign quot_o  = quot_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ----- rtl/rsv_cordic.sv -----
// Pipelined CORDIC rotator: half-turn fold, then one micro-rotation per stage
module rsv_cordic #(
  parameter int XW     = 36,
  parameter int STAGES = rsv_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsv_pkg::ctl_t        ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [31:0]          ang_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd2147483648);

  logic [STAGES:0]     v_q;
  logic signed [XW-1:0] x_q [STAGES+1];
  logic signed [XW-1:0] y_q [STAGES+1];
  logic signed [ZW-1:0] z_q [STAGES+1];
  logic [SIDE_W-1:0]   side_q [STAGES+1];

  // fold the angle into [-1/4, 1/4] turn
  logic signed [ZW-1:0] z0;
  logic                 flip;
  assign z0   = ZW'($signed(ang_i));
  assign flip = (z0 > QUARTER) || (z0 < -QUARTER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      x_q[0]    <= flip ? -x_i : x_i;
      y_q[0]    <= flip ? -y_i : y_i;
      z_q[0]    <= flip ? ((z0 > 0) ? z0 - HALF : z0 + HALF) : z0;
      side_q[0] <= side_i;
    end
  end

  // micro-rotation stages
  for (genvar k = 0; k < STAGES; k++) begin : g_rot
    logic signed [ZW-1:0] atan_k;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 pos;

    assign atan_k = $signed({{(ZW-32){1'b0}}, rsv_pkg::ATAN_TURNS[k]});
    assign xs     = x_q[k] >>> k;
    assign ys     = y_q[k] >>> k;
    assign pos    = !z_q[k][ZW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        x_q[k+1]    <= pos ? x_q[k] - ys : x_q[k] + ys;
        y_q[k+1]    <= pos ? y_q[k] + xs : y_q[k] - xs;
        z_q[k+1]    <= pos ? z_q[k] - atan_k : z_q[k] + atan_k;
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign x_o     = x_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule

// ----- rtl/rsv_phase.sv -----
// Phase unit: |w| * t * (2^64 / 2pi) in 32x32 partial products, fraction of a turn
module rsv_phase #(
  parameter int SIDE_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsv_pkg::ctl_t      ctl_i,
  input  logic signed [63:0] w_i,
  input  logic [47:0]        t_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic [31:0]        phase_o,
  output logic [SIDE_W-1:0]  side_o
);

  logic [5:0]        v_q;
  logic [SIDE_W-1:0] side_q [6];
  logic [4:0]        neg_q;

  // stage 1: magnitude and sign
  logic [63:0] w_abs;
  logic [62:0] m_q;
  logic [47:0] t1_q;
  assign w_abs = w_i[63] ? (64'd0 - w_i) : w_i;

  // stage 2: m * t partial products
  logic [63:0] pp0_q, pp1_q, pp2_q, pp3_q;

  // stage 3: full product m * t
  logic [111:0] p_q;

  // stage 4: p * inv2pi partial products
  logic [63:0] a0_q [4];
  logic [63:0] a1_q [4];

  // stage 5: row sums
  logic [143:0] s0_q, s1_q;

  // stage 6: total and turn fraction
  logic [175:0] tot;
  logic [31:0]  frac;
  logic [31:0]  phase_q;

  assign tot  = {32'd0, s0_q} + {s1_q, 32'd0};
  assign frac = tot[141:110];

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[4:0], ctl_i.valid};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      m_q   <= w_abs[62:0];
      t1_q  <= t_i;
      neg_q <= {neg_q[3:0], w_i[63]};

      pp0_q <= 64'(m_q[31:0]) * 64'(t1_q[31:0]);
      pp1_q <= 64'(m_q[31:0]) * 64'(t1_q[47:32]);
      pp2_q <= 64'(m_q[62:32]) * 64'(t1_q[31:0]);
      pp3_q <= 64'(m_q[62:32]) * 64'(t1_q[47:32]);

      p_q <= {48'd0, pp0_q} + {16'd0, pp1_q, 32'd0} + {16'd0, pp2_q, 32'd0}
           + {pp3_q[47:0], 64'd0};

      a0_q[0] <= 64'(p_q[31:0])   * 64'(rsv_pkg::INV2PI_LO);
      a0_q[1] <= 64'(p_q[63:32])  * 64'(rsv_pkg::INV2PI_LO);
      a0_q[2] <= 64'(p_q[95:64])  * 64'(rsv_pkg::INV2PI_LO);
      a0_q[3] <= 64'(p_q[111:96]) * 64'(rsv_pkg::INV2PI_LO);
      a1_q[0] <= 64'(p_q[31:0])   * 64'(rsv_pkg::INV2PI_HI);
      a1_q[1] <= 64'(p_q[63:32])  * 64'(rsv_pkg::INV2PI_HI);
      a1_q[2] <= 64'(p_q[95:64])  * 64'(rsv_pkg::INV2PI_HI);
      a1_q[3] <= 64'(p_q[111:96]) * 64'(rsv_pkg::INV2PI_HI);

      s0_q <= {80'd0, a0_q[0]} + {48'd0, a0_q[1], 32'd0}
            + {16'd0, a0_q[2], 64'd0} + {a0_q[3][47:0], 96'd0};
      s1_q <= {80'd0, a1_q[0]} + {48'd0, a1_q[1], 32'd0}
            + {16'd0, a1_q[2], 64'd0} + {a1_q[3][47:0], 96'd0};

      // negative frequency turns the other way
      phase_q <= neg_q[4] ? (32'd0 - frac) : frac;

      side_q[0] <= side_i;
      for (int s = 1; s < 6; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = v_q[5];
  assign phase_o = phase_q;
  assign side_o  = side_q[5];

endmodule

// ----- rtl/ramped_sine_voltage_source_unit.sv -----
// Top level of the ramped sine voltage source: registers, ramp logic, pipeline
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+----------------------
//   input    | in        | in_valid_i / in_stall_o     | sim_time_i [47:0]
//   output   | out       | out_valid_o / out_stall_i   | voltage_out_o [31:0]
//   config   | in / out  | psel penable pwrite pready  | paddr pwdata prdata
//
// One transaction enters per cycle unless the output is stalled; the pipeline holds
// 30 divider stages, two CORDIC rotators of CORDIC_STAGES + 1 stages each,
// six stages of phase multiplication and six stages of setup and output.
// Reset clears the valid bits and the configuration registers; no clearing pass.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module ramped_sine_voltage_source_unit #(
  parameter int CORDIC_STAGES = rsv_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [47:0] sim_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] voltage_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int LW = rsv_pkg::LIN_W;
  localparam int FXW = 36;
  localparam int MXW = 62;
  localparam logic signed [FXW-1:0] FADE_X0 = FXW'(64'sd652032896);
  localparam logic [LW:0] ONE_LIN = {1'b1, {LW{1'b0}}};

  // configuration registers
  logic signed [31:0] ref_real_q, ref_imag_q, add_real_q, add_imag_q;
  logic signed [31:0] base_omega_q, add_omega_q;
  logic [47:0] switch_time_q, ramp_length_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_real_q    <= '0;
      ref_imag_q    <= '0;
      add_real_q    <= '0;
      add_imag_q    <= '0;
      base_omega_q  <= '0;
      add_omega_q   <= '0;
      switch_time_q <= '0;
      ramp_length_q <= '0;
    end else if (wr_en) begin
      case (paddr[5:3])
        rsv_pkg::REG_REF_REAL:    ref_real_q    <= pwdata[31:0];
        rsv_pkg::REG_REF_IMAG:    ref_imag_q    <= pwdata[31:0];
        rsv_pkg::REG_ADD_REAL:    add_real_q    <= pwdata[31:0];
        rsv_pkg::REG_ADD_IMAG:    add_imag_q    <= pwdata[31:0];
        rsv_pkg::REG_BASE_OMEGA:  base_omega_q  <= pwdata[31:0];
        rsv_pkg::REG_ADD_OMEGA:   add_omega_q   <= pwdata[31:0];
        rsv_pkg::REG_SWITCH_TIME: switch_time_q <= pwdata[47:0];
        rsv_pkg::REG_RAMP_LENGTH: ramp_length_q <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[5:3])
      rsv_pkg::REG_REF_REAL:    prdata = {32'd0, ref_real_q};
      rsv_pkg::REG_REF_IMAG:    prdata = {32'd0, ref_imag_q};
      rsv_pkg::REG_ADD_REAL:    prdata = {32'd0, add_real_q};
      rsv_pkg::REG_ADD_IMAG:    prdata = {32'd0, add_imag_q};
      rsv_pkg::REG_BASE_OMEGA:  prdata = {32'd0, base_omega_q};
      rsv_pkg::REG_ADD_OMEGA:   prdata = {32'd0, add_omega_q};
      rsv_pkg::REG_SWITCH_TIME: prdata = {16'd0, switch_time_q};
      rsv_pkg::REG_RAMP_LENGTH: prdata = {16'd0, ramp_length_q};
      default:                  prdata = '0;
    endcase
  end

  // global advance: everything moves unless the output transaction is held
  logic          adv;
  logic          out_valid_q;
  rsv_pkg::ctl_t ctl_div, ctl_fade, ctl_f, ctl_p, ctl_s, ctl_k, ctl_ph;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage 0: window decode and elapsed time
  logic        v0_q, in_win_q, after_q;
  logic [47:0] t0_q, rem0_q;
  logic [48:0] win_end;
  logic        past_sw, before_end;

  assign win_end    = {1'b0, switch_time_q} + {1'b0, ramp_length_q};
  assign past_sw    = sim_time_i >= switch_time_q;
  assign before_end = {1'b0, sim_time_i} < win_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t0_q     <= sim_time_i;
      rem0_q   <= sim_time_i - switch_time_q;
      in_win_q <= past_sw && before_end;
      after_q  <= past_sw && !before_end;
    end
  end

  // ramp fraction
  logic              div_valid;
  logic [LW-1:0]     div_quot;
  logic [49:0]       div_side;

  assign ctl_div = '{valid: v0_q, en: adv};

  rsv_divider #(.SIDE_W(50)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_div),
    .rem_i  (rem0_q),
    .den_i  (ramp_length_q),
    .side_i ({t0_q, in_win_q, after_q}),
    .valid_o(div_valid),
    .quot_o (div_quot),
    .side_o (div_side)
  );

  // cosine of half a turn times the ramp fraction
  logic                  fade_valid;
  logic signed [FXW-1:0] fade_c;
  logic [79:0]           fade_side;

  assign ctl_fade = '{valid: div_valid, en: adv};

  rsv_cordic #(.XW(FXW), .STAGES(CORDIC_STAGES), .SIDE_W(80)) u_fade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_fade),
    .x_i    (FADE_X0),
    .y_i    ('0),
    .ang_i  ({1'b0, div_quot, 1'b0}),
    .side_i ({div_side, div_quot}),
    .valid_o(fade_valid),
    .x_o    (fade_c),
    .side_o (fade_side)
  );

  // stage F: raised-cosine fade, clamped, and selection by window
  logic signed [FXW:0] fade_diff;
  logic signed [FXW:0] fade_half;
  logic [LW:0]         fade_clamped;
  logic                vf_q;
  logic [LW:0]         lin_f_q, fade_f_q;
  logic [47:0]         t_f_q;

  assign fade_diff = (FXW+1)'($signed({1'b0, ONE_LIN})) - (FXW+1)'(fade_c);
  assign fade_half = fade_diff >>> 1;

  always_comb begin
    if (fade_half[FXW]) begin
      fade_clamped = '0;
    end else if (fade_half > (FXW+1)'($signed({1'b0, ONE_LIN}))) begin
      fade_clamped = ONE_LIN;
    end else begin
      fade_clamped = fade_half[LW:0];
    end
  end

  assign ctl_f = '{valid: fade_valid, en: adv};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (ctl_f.en) begin
      vf_q <= ctl_f.valid;
    end
  end

  // side layout: t, in_win, after, quotient
  always_ff @(posedge clk_i) begin
    if (ctl_f.en) begin
      t_f_q <= fade_side[79:32];
      if (fade_side[30]) begin
        lin_f_q  <= ONE_LIN;
        fade_f_q <= ONE_LIN;
      end else if (fade_side[31]) begin
        lin_f_q  <= {1'b0, fade_side[LW-1:0]};
        fade_f_q <= fade_clamped;
      end else begin
        lin_f_q  <= '0;
        fade_f_q <= '0;
      end
    end
  end

  // stage P: ramp products
  logic               vp_q;
  logic signed [63:0] prod_r_q, prod_i_q, prod_w_q;
  logic [47:0]        t_p_q;

  assign ctl_p = '{valid: vf_q, en: adv};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (ctl_p.en) begin
      vp_q <= ctl_p.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_p.en) begin
      prod_r_q <= 64'($signed({1'b0, lin_f_q})) * 64'(add_real_q);
      prod_i_q <= 64'($signed({1'b0, lin_f_q})) * 64'(add_imag_q);
      prod_w_q <= 64'($signed({1'b0, fade_f_q})) * 64'(add_omega_q);
      t_p_q    <= t_f_q;
    end
  end

  // stage S: phasor and effective frequency
  logic               vs_q;
  logic signed [63:0] sum_r, sum_i, w_d;
  logic signed [33:0] vr_q, vi_q;
  logic signed [63:0] w_s_q;
  logic [47:0]        t_s_q;

  assign sum_r = $signed({{2{ref_real_q[31]}}, ref_real_q, {LW{1'b0}}}) + prod_r_q;
  assign sum_i = $signed({{2{ref_imag_q[31]}}, ref_imag_q, {LW{1'b0}}}) + prod_i_q;
  assign w_d   = $signed({{2{base_omega_q[31]}}, base_omega_q, {LW{1'b0}}}) + prod_w_q;

  assign ctl_s = '{valid: vp_q, en: adv};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (ctl_s.en) begin
      vs_q <= ctl_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_s.en) begin
      vr_q  <= sum_r[63:30];
      vi_q  <= sum_i[63:30];
      w_s_q <= w_d;
      t_s_q <= t_p_q;
    end
  end

  // stage K: pre-scale by the CORDIC gain
  logic               vk_q;
  logic signed [58:0] xk_q, yk_q;
  logic signed [63:0] w_k_q;
  logic [47:0]        t_k_q;

  assign ctl_k = '{valid: vs_q, en: adv};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q <= 1'b0;
    end else if (ctl_k.en) begin
      vk_q <= ctl_k.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_k.en) begin
      xk_q  <= 59'(vr_q) * 59'(rsv_pkg::GAIN_Q24);
      yk_q  <= 59'(vi_q) * 59'(rsv_pkg::GAIN_Q24);
      w_k_q <= w_s_q;
      t_k_q <= t_s_q;
    end
  end

  // phase of the effective frequency at this time
  logic         ph_valid;
  logic [31:0]  ph_turns;
  logic [117:0] ph_side;

  assign ctl_ph = '{valid: vk_q, en: adv};

  rsv_phase #(.SIDE_W(118)) u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_ph),
    .w_i    (w_k_q),
    .t_i    (t_k_q),
    .side_i ({xk_q, yk_q}),
    .valid_o(ph_valid),
    .phase_o(ph_turns),
    .side_o (ph_side)
  );

  // rotate the phasor and keep the real part
  rsv_pkg::ctl_t         ctl_rot;
  logic                  rot_valid;
  logic signed [MXW-1:0] rot_x;

  assign ctl_rot = '{valid: ph_valid, en: adv};

  rsv_cordic #(.XW(MXW), .STAGES(CORDIC_STAGES), .SIDE_W(1)) u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_rot),
    .x_i    (MXW'($signed(ph_side[117:59]))),
    .y_i    (MXW'($signed(ph_side[58:0]))),
    .ang_i  (ph_turns),
    .side_i (1'b0),
    .valid_o(rot_valid),
    .x_o    (rot_x),
    .side_o ()
  );

  // output register: round, drop the Q24 scale, saturate
  logic signed [MXW:0]     rounded;
  logic signed [MXW-24:0]  scaled;
  logic signed [31:0]      sat;
  logic signed [31:0]      voltage_q;

  assign rounded = (MXW+1)'(rot_x) + (MXW+1)'(64'sd8388608);
  assign scaled  = rounded[MXW:24];

  always_comb begin
    if (scaled > (MXW-23)'(64'sd2147483647)) begin
      sat = 32'sh7FFFFFFF;
    end else if (scaled < (MXW-23)'(-64'sd2147483648)) begin
      sat = 32'sh80000000;
    end else begin
      sat = scaled[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= rot_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      voltage_q <= sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign voltage_out_o = voltage_q;

endmodule

// ----- rtl/rsv_checker.sv -----
// Port-level checker for the ramped sine voltage source, bound to the top level
`include "ramped_sine_voltage_source_unit_assert.svh"

module rsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] voltage_out_o,
  input logic        pready
);

  // a held result stays on the port
  `RSV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(voltage_out_o), "held output transaction changed")

  // the input stalls only behind a blocked result
  `RSV_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without a blocked output")

  // register port never waits
  `RSV_ASSERT_NOW(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind ramped_sine_voltage_source_unit rsv_checker u_rsv_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the ramped sine voltage source unit
`timescale 1ns / 1ps

module tb_top;
  import rsv_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int LATENCY = 2 * STAGES + 44;
  localparam int IDLE_LIMIT = 5000;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint GAIN = 64'sd10188014;

  // Expected voltages, worked out from the register copy at input acceptance
  class voltage_scoreboard;
    longint ref_re, ref_im, add_re, add_im, base_om, add_om;
    bit [47:0] sw_time, ramp_len;
    logic signed [31:0] volt_q[$];
    int errors;

    function void set_reg(logic [2:0] idx, bit [63:0] v);
      case (idx)
        REG_REF_REAL:    ref_re = longint'(signed'(v[31:0]));
        REG_REF_IMAG:    ref_im = longint'(signed'(v[31:0]));
        REG_ADD_REAL:    add_re = longint'(signed'(v[31:0]));
        REG_ADD_IMAG:    add_im = longint'(signed'(v[31:0]));
        REG_BASE_OMEGA:  base_om = longint'(signed'(v[31:0]));
        REG_ADD_OMEGA:   add_om = longint'(signed'(v[31:0]));
        REG_SWITCH_TIME: sw_time = v[47:0];
        REG_RAMP_LENGTH: ramp_len = v[47:0];
        default: ;
      endcase
    endfunction

    // CORDIC rotation of (x, y) by ang turns, x component only
    function longint rotated_x(longint x, longint y, bit [31:0] ang);
      longint z, t;
      z = longint'({32'b0, ang});
      if (z >= 64'sd2147483648) z -= 64'sd4294967296;
      if (z > ONE_Q30 || z < -ONE_Q30) begin
        x = -x;
        y = -y;
        z += (z > 0) ? -64'sd2147483648 : 64'sd2147483648;
      end
      for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'({32'b0, ATAN_TURNS[i]});
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'({32'b0, ATAN_TURNS[i]});
        end
        x = t;
      end
      return x;
    endfunction

    // phase in turns of w * t, w with 46 fraction bits
    function bit [31:0] phase_of(longint w, bit [47:0] t);
      bit [63:0] mag;
      bit [191:0] prod;
      bit [31:0] frac;
      mag = (w < 0) ? -w : w;
      prod = (192'(mag) * 192'(t)) * 192'({INV2PI_HI, INV2PI_LO});
      frac = prod[141:110];
      if (w < 0) frac = -frac;
      return frac;
    endfunction

    function logic signed [31:0] voltage_at(bit [47:0] t);
      longint lin, fade, vr, vi, w, x, c;
      bit [63:0] rem, q;
      lin = 0;
      fade = 0;
      if (t >= sw_time && 64'(t) < 64'(sw_time) + 64'(ramp_len)) begin
        rem = 64'(t - sw_time);
        q = 0;
        for (int i = 0; i < LIN_W; i++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= 64'(ramp_len)) begin
            rem -= 64'(ramp_len);
            q[0] = 1'b1;
          end
        end
        lin = longint'(q);
        c = rotated_x(GAIN * 64, 0, 32'(q * 2));
        fade = (ONE_Q30 - c) >>> 1;
        if (fade < 0) fade = 0;
        if (fade > ONE_Q30) fade = ONE_Q30;
      end else if (t >= sw_time) begin
        lin = ONE_Q30;
        fade = ONE_Q30;
      end
      vr = (ref_re * ONE_Q30 + lin * add_re) >>> 30;
      vi = (ref_im * ONE_Q30 + lin * add_im) >>> 30;
      w = base_om * ONE_Q30 + fade * add_om;
      x = rotated_x(vr * GAIN, vi * GAIN, phase_of(w, t));
      x = (x + 64'sd8388608) >>> 24;
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      return 32'(x);
    endfunction

    function void note_input(bit [47:0] t);
      volt_q.insert(volt_q.size(), voltage_at(t));
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic signed [31:0] v);
      logic signed [31:0] e;
      if (volt_q.size() == 0) begin
        report_mismatch($sformatf("unexpected voltage_out %0d", v));
      end else begin
        e = volt_q.pop_front();
        if (v !== e)
          report_mismatch($sformatf("voltage_out %0d, expected %0d", v, e));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [47:0] sim_time_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] voltage_out_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  voltage_scoreboard sb;
  bit idle_on;
  bit hold_req;
  int quiet_cycles;
  bit [47:0] cur_sw, cur_rl;

  always #5 clk_i = ~clk_i;

  ramped_sine_voltage_source_unit #(.CORDIC_STAGES(STAGES)) dut (.*);

  // output monitor and progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(voltage_out_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall: random per transaction, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end
      n = idle_on ? $urandom_range(16) : 0;
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task reg_write(logic [2:0] idx, bit [63:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (pready) sb.set_reg(idx, v);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_SWITCH_TIME) cur_sw = v[47:0];
    if (idx == REG_RAMP_LENGTH) cur_rl = v[47:0];
  endtask

  // one time sample offered until accepted
  task send_time(bit [47:0] t);
    int gap;
    gap = idle_on ? $urandom_range(16) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sim_time_i = t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(t);
    @(negedge clk_i);
  endtask

  // called at a falling edge: stop offering, then wait for every result
  task drain;
    in_valid_i = 1'b0;
    while (sb.volt_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  function bit [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  function bit [31:0] rand_reg32();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom() >>> $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  // time samples clustered around the ramp window
  function bit [47:0] pick_time();
    bit [63:0] v;
    case ($urandom_range(7))
      0: v = rand48();
      1: v = 64'(cur_sw) - $urandom_range(1000);
      2: v = 64'(cur_sw) + (cur_rl == 0 ? 0 : 64'(rand48()) % 64'(cur_rl));
      3: v = 64'(cur_sw) + 64'(cur_rl) + $urandom_range(1000) - 1;
      4: v = 0;
      5: v = 48'hFFFF_FFFF_FFFF;
      default: v = 64'(cur_sw) + (cur_rl == 0 ? 0 : 64'(rand48()) % 64'(cur_rl));
    endcase
    return v[47:0];
  endfunction

  task random_config();
    for (int i = REG_REF_REAL; i <= REG_ADD_OMEGA; i++)
      reg_write(3'(i), {32'b0, rand_reg32()});
    case ($urandom_range(3))
      0: reg_write(REG_SWITCH_TIME, 64'h0);
      1: reg_write(REG_SWITCH_TIME, 64'h0000_FFFF_FFFF_FFFF);
      2: reg_write(REG_SWITCH_TIME, 64'(rand48()));
      default: reg_write(REG_SWITCH_TIME, 64'($urandom()));
    endcase
    case ($urandom_range(4))
      0: reg_write(REG_RAMP_LENGTH, 64'h0);
      1: reg_write(REG_RAMP_LENGTH, 64'h1);
      2: reg_write(REG_RAMP_LENGTH, 64'h0000_FFFF_FFFF_FFFF);
      3: reg_write(REG_RAMP_LENGTH, 64'(rand48()));
      default: reg_write(REG_RAMP_LENGTH, 64'($urandom_range(100000, 1)));
    endcase
  endtask

  initial begin
    sb = new();
    idle_on = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    cur_sw = '0;
    cur_rl = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // registers at reset value
    send_time(48'h0);
    send_time(48'hFFFF_FFFF_FFFF);
    drain();

    // directed: full ramp, window edges, field extremes
    reg_write(REG_REF_REAL, 64'h0000_0000_7FFF_FFFF);
    reg_write(REG_REF_IMAG, 64'h0000_0000_8000_0000);
    reg_write(REG_ADD_REAL, 64'h0000_0000_8000_0000);
    reg_write(REG_ADD_IMAG, 64'h0000_0000_7FFF_FFFF);
    reg_write(REG_BASE_OMEGA, 64'h0000_0000_7FFF_FFFF);
    reg_write(REG_ADD_OMEGA, 64'h0000_0000_8000_0000);
    reg_write(REG_SWITCH_TIME, 64'h0000_0000_1000_0000);
    reg_write(REG_RAMP_LENGTH, 64'h0000_0000_0100_0000);
    send_time(48'h0);
    send_time(48'h0FFF_FFFF);
    send_time(48'h1000_0000);
    send_time(48'h1000_0001);
    send_time(48'h1080_0000);
    send_time(48'h10FF_FFFF);
    send_time(48'h1100_0000);
    send_time(48'hFFFF_FFFF_FFFF);
    drain();

    // zero ramp length jumps to the final values
    reg_write(REG_RAMP_LENGTH, 64'h0);
    send_time(48'h0FFF_FFFF);
    send_time(48'h1000_0000);
    send_time(48'h1000_0001);
    drain();

    // unit ramp length and window at the top of the time range
    reg_write(REG_RAMP_LENGTH, 64'h1);
    send_time(48'h1000_0000);
    drain();
    reg_write(REG_SWITCH_TIME, 64'h0000_FFFF_FFFF_FFFF);
    reg_write(REG_RAMP_LENGTH, 64'h0000_FFFF_FFFF_FFFF);
    send_time(48'hFFFF_FFFF_FFFE);
    send_time(48'hFFFF_FFFF_FFFF);
    drain();

    // random phases, one of them with a long receiver hold-off
    for (int ph = 0; ph < 20; ph++) begin
      random_config();
      idle_on = (ph % 3 != 0);
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < 80; k++) send_time(pick_time());
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
